// ----- hdl/uhfrx_pkg.sv -----
// ----------------------------------------------------------------------------
// uhfrx_pkg
// shared constants, codes and handshake structs of the uhf reader frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package uhfrx_pkg;

    // frame store size and derived widths
    localparam int FRAME_MAX = 128;
    localparam int EPC_MAX   = 12;
    localparam int ADDR_W    = $clog2(FRAME_MAX);
    localparam int CNT_W     = $clog2(FRAME_MAX + 1);
    localparam int ELEN_W    = $clog2(EPC_MAX + 1);

    // framing bytes and command codes
    localparam logic [7:0] START_BYTE    = 8'hBB;
    localparam logic [7:0] END_BYTE      = 8'h7E;
    localparam logic [7:0] CMD_INVENTORY = 8'h22;
    localparam logic [7:0] CMD_ERROR     = 8'hFF;

    // frame layout
    localparam int FRAME_OVERHEAD = 7;
    localparam int TAG_OVERHEAD   = 5;
    localparam int POS_CMD        = 2;
    localparam int POS_LEN_HI     = 3;
    localparam int POS_LEN_LO     = 4;
    localparam int POS_RSSI       = 5;
    localparam int POS_PC_HI      = 6;
    localparam int POS_PC_LO      = 7;
    localparam int POS_EPC        = 8;

    typedef enum logic [1:0] {
        KIND_TAG    = 2'd0,
        KIND_ERROR  = 2'd1,
        KIND_OTHER  = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MISC,
        ST_RD,
        ST_EPC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic take_byte;
        logic tag_init;
        logic rd_epc;
        logic emit_epc;
        logic emit_misc;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic frame_end;
        logic frame_ok;
        logic tag_ok;
        logic epc_last;
        logic out_free;
    } dp_status_t;

endpackage : uhfrx_pkg

`default_nettype wire

// ----- hdl/uhf_reader_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// uhf_reader_frame_receiver_top
// deframer for uhf reader replies with additive checksum and tag read split
// ----------------------------------------------------------------------------
// Each request on the input carries one received byte. The block hunts for
// the 0xBB start byte, stores bytes into a 128-entry frame store, and on the
// 0x7E end byte checks the length field (length + 7 bytes) and the 8-bit
// additive checksum. Bad or overlong frames vanish without a result. A good
// inventory reply with 1..12 epc bytes gives one result per epc byte (last
// marks the final one); any other good frame gives one result. A byte that
// does not end a frame is taken without a stall. After an end byte in_stall
// stays high while the frame is checked and, on a good frame, while its
// results are loaded: a non-tag frame passes the check and load states, and
// a tag read passes the check state and then a read state and a load state
// for each epc byte, as the frame store has one read port. The stall also
// lasts while out_stall holds a result back.
// ----------------------------------------------------------------------------
`default_nettype none

module uhf_reader_frame_receiver_top
    import uhfrx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // byte requests
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        restart,

    // result requests
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       command,
    output logic signed [7:0] rssi_dbm,
    output logic [15:0]      pc_word,
    output logic [15:0]      tag_crc,
    output logic [3:0]       epc_length,
    output logic [3:0]       epc_index,
    output logic [7:0]       epc_byte,
    output logic             last
);

    // command and status between sequencer and datapath
    ctrl_cmd_t  cmd;
    dp_status_t st;

    // sequencer: byte intake, frame check, result emission
    uhfrx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .st       (st),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // datapath: frame store, checksum, header capture, result register
    uhfrx_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .rx_byte    (rx_byte),
        .restart    (restart),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .st         (st),
        .out_valid  (out_valid),
        .kind       (kind),
        .command    (command),
        .rssi_dbm   (rssi_dbm),
        .pc_word    (pc_word),
        .tag_crc    (tag_crc),
        .epc_length (epc_length),
        .epc_index  (epc_index),
        .epc_byte   (epc_byte),
        .last       (last)
    );

endmodule : uhf_reader_frame_receiver_top

`default_nettype wire

// ----- hdl/uhfrx_ram.sv -----
// ----------------------------------------------------------------------------
// uhfrx_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module uhfrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule : uhfrx_ram

`default_nettype wire

// ----- hdl/uhfrx_dpath.sv -----
// ----------------------------------------------------------------------------
// uhfrx_dpath
// byte collection, frame checks, header capture, frame store and result register
// ----------------------------------------------------------------------------
`default_nettype none

module uhfrx_dpath
    import uhfrx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        restart,
    input  wire logic        out_stall,
    input  wire ctrl_cmd_t   cmd,
    output dp_status_t       st,
    output logic             out_valid,
    output logic [1:0]       kind,
    output logic [7:0]       command,
    output logic signed [7:0] rssi_dbm,
    output logic [15:0]      pc_word,
    output logic [15:0]      tag_crc,
    output logic [3:0]       epc_length,
    output logic [3:0]       epc_index,
    output logic [7:0]       epc_byte,
    output logic             last
);

    // frame collection state
    logic              in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [7:0]        sum_reg, sum_next;
    logic [CNT_W-1:0]  len_reg, len_next;

    // last three data bytes before the end byte
    logic [7:0] h1_reg, h1_next;
    logic [7:0] h2_reg, h2_next;
    logic [7:0] h3_reg, h3_next;

    // header bytes at fixed positions
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] lhi_reg, lhi_next;
    logic [7:0] llo_reg, llo_next;
    logic [7:0] rssi_reg, rssi_next;
    logic [7:0] pchi_reg, pchi_next;
    logic [7:0] pclo_reg, pclo_next;

    // epc walk
    logic [ELEN_W-1:0] epc_idx_reg, epc_idx_next;
    logic [ELEN_W-1:0] elen_reg, elen_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    logic [7:0]        out_cmd_reg, out_cmd_next;
    logic [7:0]        out_rssi_reg, out_rssi_next;
    logic [15:0]       out_pc_reg, out_pc_next;
    logic [15:0]       out_crc_reg, out_crc_next;
    logic [3:0]        out_elen_reg, out_elen_next;
    logic [3:0]        out_eidx_reg, out_eidx_next;
    logic [7:0]        out_eb_reg, out_eb_next;
    logic              out_last_reg, out_last_next;

    logic              in_accept;
    logic              hunting;
    logic              start_ok;
    logic [CNT_W-1:0]  count_eff;
    logic [7:0]        sum_eff;
    logic              overflow;
    logic              store;
    logic              is_end;
    logic [15:0]       payload;
    logic [15:0]       elen_full;
    logic              len_ok;
    logic              sum_ok;
    logic              epc_last;
    logic              out_free;
    logic [7:0]        ram_rdata;
    logic [ADDR_W-1:0] ram_raddr;

    assign in_accept = in_valid && cmd.take_byte;
    assign hunting   = restart || !in_frame_reg;
    assign start_ok  = !hunting || (rx_byte == START_BYTE);
    assign count_eff = hunting ? '0 : count_reg;
    assign sum_eff   = hunting ? '0 : sum_reg;
    assign overflow  = (count_eff >= CNT_W'(FRAME_MAX));
    assign store     = in_accept && start_ok && !overflow;
    assign is_end    = (rx_byte == END_BYTE);

    // frame checks on the held registers
    assign payload   = {lhi_reg, llo_reg};
    assign elen_full = payload - 16'(TAG_OVERHEAD);
    assign len_ok    = (len_reg >= CNT_W'(FRAME_OVERHEAD))
                    && (17'(len_reg) == (17'(payload) + 17'(FRAME_OVERHEAD)));
    assign sum_ok    = ((sum_reg - h1_reg) == h1_reg);
    assign epc_last  = (epc_idx_reg == (elen_reg - ELEN_W'(1)));
    assign out_free  = !out_valid_reg || !out_stall;

    assign st.frame_end = store && is_end;
    assign st.frame_ok  = len_ok && sum_ok;
    assign st.tag_ok    = (cmd_reg == CMD_INVENTORY)
                       && (payload >= 16'(TAG_OVERHEAD + 1))
                       && (elen_full <= 16'(EPC_MAX));
    assign st.epc_last  = epc_last;
    assign st.out_free  = out_free;

    assign ram_raddr = ADDR_W'(POS_EPC) + ADDR_W'(epc_idx_reg);

    uhfrx_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_MAX)
    ) u_store (
        .clk   (clk),
        .we    (store),
        .waddr (count_eff[ADDR_W-1:0]),
        .wdata (rx_byte),
        .re    (cmd.rd_epc),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        len_next      = len_reg;
        h1_next       = h1_reg;
        h2_next       = h2_reg;
        h3_next       = h3_reg;
        cmd_next      = cmd_reg;
        lhi_next      = lhi_reg;
        llo_next      = llo_reg;
        rssi_next     = rssi_reg;
        pchi_next     = pchi_reg;
        pclo_next     = pclo_reg;
        if (in_accept)
        begin
            priority if (!start_ok || overflow)
            begin
                in_frame_next = 1'b0;
            end
            else if (is_end)
            begin
                in_frame_next = 1'b0;
                len_next      = count_eff + CNT_W'(1);
            end
            else
            begin
                in_frame_next = 1'b1;
                count_next    = count_eff + CNT_W'(1);
                sum_next      = (count_eff != '0) ? (sum_eff + rx_byte) : sum_eff;
                h1_next       = rx_byte;
                h2_next       = h1_reg;
                h3_next       = h2_reg;
                if (count_eff == CNT_W'(POS_CMD))    cmd_next  = rx_byte;
                if (count_eff == CNT_W'(POS_LEN_HI)) lhi_next  = rx_byte;
                if (count_eff == CNT_W'(POS_LEN_LO)) llo_next  = rx_byte;
                if (count_eff == CNT_W'(POS_RSSI))   rssi_next = rx_byte;
                if (count_eff == CNT_W'(POS_PC_HI))  pchi_next = rx_byte;
                if (count_eff == CNT_W'(POS_PC_LO))  pclo_next = rx_byte;
            end
        end
    end

    always_comb
    begin
        epc_idx_next   = epc_idx_reg;
        elen_next      = elen_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_cmd_next   = out_cmd_reg;
        out_rssi_next  = out_rssi_reg;
        out_pc_next    = out_pc_reg;
        out_crc_next   = out_crc_reg;
        out_elen_next  = out_elen_reg;
        out_eidx_next  = out_eidx_reg;
        out_eb_next    = out_eb_reg;
        out_last_next  = out_last_reg;

        if (cmd.tag_init)
        begin
            epc_idx_next = '0;
            elen_next    = elen_full[ELEN_W-1:0];
        end

        priority if (cmd.emit_misc)
        begin
            out_valid_next = 1'b1;
            if (cmd_reg == CMD_ERROR)
                out_kind_next = KIND_ERROR;
            else if (cmd_reg == CMD_INVENTORY)
                out_kind_next = KIND_REJECT;
            else
                out_kind_next = KIND_OTHER;
            out_cmd_next  = cmd_reg;
            out_rssi_next = '0;
            out_pc_next   = '0;
            out_crc_next  = '0;
            out_elen_next = '0;
            out_eidx_next = '0;
            out_eb_next   = '0;
            out_last_next = 1'b1;
        end
        else if (cmd.emit_epc)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_TAG;
            out_cmd_next   = cmd_reg;
            out_rssi_next  = rssi_reg;
            out_pc_next    = {pchi_reg, pclo_reg};
            out_crc_next   = {h3_reg, h2_reg};
            out_elen_next  = 4'(elen_reg);
            out_eidx_next  = 4'(epc_idx_reg);
            out_eb_next    = ram_rdata;
            out_last_next  = epc_last;
            epc_idx_next   = epc_idx_reg + ELEN_W'(1);
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        h1_reg       <= h1_next;
        h2_reg       <= h2_next;
        h3_reg       <= h3_next;
        cmd_reg      <= cmd_next;
        lhi_reg      <= lhi_next;
        llo_reg      <= llo_next;
        rssi_reg     <= rssi_next;
        pchi_reg     <= pchi_next;
        pclo_reg     <= pclo_next;
        epc_idx_reg  <= epc_idx_next;
        elen_reg     <= elen_next;
        out_kind_reg <= out_kind_next;
        out_cmd_reg  <= out_cmd_next;
        out_rssi_reg <= out_rssi_next;
        out_pc_reg   <= out_pc_next;
        out_crc_reg  <= out_crc_next;
        out_elen_reg <= out_elen_next;
        out_eidx_reg <= out_eidx_next;
        out_eb_reg   <= out_eb_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = out_kind_reg;
    assign command    = out_cmd_reg;
    assign rssi_dbm   = $signed(out_rssi_reg);
    assign pc_word    = out_pc_reg;
    assign tag_crc    = out_crc_reg;
    assign epc_length = out_elen_reg;
    assign epc_index  = out_eidx_reg;
    assign epc_byte   = out_eb_reg;
    assign last       = out_last_reg;

    // a result is only loaded when the output slot is free
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_epc || cmd.emit_misc) |-> out_free)
        else $error("result loaded while output still held");

    // only one result source at a time
    a_one_source : assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_epc && cmd.emit_misc))
        else $error("two result sources in one cycle");

    // an end byte always closes the frame
    a_end_closes : assert property (@(posedge clk) disable iff (!rst_n)
        st.frame_end |=> !in_frame_reg)
        else $error("frame still open after end byte");

endmodule : uhfrx_dpath

`default_nettype wire

// ----- hdl/uhfrx_ctrl.sv -----
// ----------------------------------------------------------------------------
// uhfrx_ctrl
// sequencer for frame check and result emission
// ----------------------------------------------------------------------------
`default_nettype none

module uhfrx_ctrl
    import uhfrx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_status_t st,
    output ctrl_cmd_t       cmd,
    output logic            in_stall
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take_byte = 1'b1;
                if (st.frame_end)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (!st.frame_ok)
                    state_next = ST_IDLE;
                else if (st.tag_ok)
                begin
                    cmd.tag_init = 1'b1;
                    state_next   = ST_RD;
                end
                else
                    state_next = ST_MISC;
            end
            ST_MISC:
            begin
                if (st.out_free)
                begin
                    cmd.emit_misc = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RD:
            begin
                cmd.rd_epc = 1'b1;
                state_next = ST_EPC;
            end
            ST_EPC:
            begin
                if (st.out_free)
                begin
                    cmd.emit_epc = 1'b1;
                    state_next   = st.epc_last ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = !cmd.take_byte;

    // an end byte is always followed by the check step
    a_end_to_check : assert property (@(posedge clk) disable iff (!rst_n)
        st.frame_end |=> (state_reg == ST_CHECK))
        else $error("end byte not followed by frame check");

    // the final epc result returns to byte collection
    a_last_to_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_epc && st.epc_last) |=> (state_reg == ST_IDLE))
        else $error("epc run did not finish");

    // an epc result always follows a store read
    a_epc_after_rd : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EPC) |-> ($past(state_reg) == ST_RD || $past(state_reg) == ST_EPC))
        else $error("epc result without store read");

endmodule : uhfrx_ctrl

`default_nettype wire

// ----- verif/uhfrx_checker.sv -----
// ----------------------------------------------------------------------------
// uhfrx_checker
// watches both request channels of the frame receiver, rebuilds every frame
// from the accepted bytes and compares each result request field by field
// ----------------------------------------------------------------------------
`default_nettype none

module uhfrx_checker
    import uhfrx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        restart,

    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  command,
    input  wire logic signed [7:0] rssi_dbm,
    input  wire logic [15:0] pc_word,
    input  wire logic [15:0] tag_crc,
    input  wire logic [3:0]  epc_length,
    input  wire logic [3:0]  epc_index,
    input  wire logic [7:0]  epc_byte,
    input  wire logic        last,

    output int               mismatches,
    output int               backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  command;
        logic [7:0]  rssi;
        logic [15:0] pc;
        logic [15:0] crc;
        logic [3:0]  elen;
        logic [3:0]  eidx;
        logic [7:0]  ebyte;
        logic        last;
    } report_t;

    // own copy of the deframer state
    logic       framing;
    int         fill_count;
    logic [7:0] frame_mem [FRAME_MAX];
    logic [7:0] csum;

    report_t    report_backlog [$];

    function automatic void drop_frame();
        framing    = 1'b0;
        fill_count = 0;
        csum       = 8'h00;
    endfunction

    function automatic void queue_report(kind_t k, logic [7:0] cmd, logic [7:0] rssi,
                                         logic [15:0] pc, logic [15:0] crc,
                                         logic [3:0] elen, logic [3:0] eidx,
                                         logic [7:0] eb, logic lst);
        report_t r;
        r.kind    = k;
        r.command = cmd;
        r.rssi    = rssi;
        r.pc      = pc;
        r.crc     = crc;
        r.elen    = elen;
        r.eidx    = eidx;
        r.ebyte   = eb;
        r.last    = lst;
        report_backlog.push_back(r);
    endfunction

    // one accepted byte: hunt, store, and on the end byte check and split
    function automatic void deframe_byte(logic [7:0] b, logic clr);
        int          n;
        int          elen;
        logic [15:0] plen;
        logic [7:0]  sum_in;
        logic [7:0]  chk;
        logic [7:0]  cmd;
        if (clr)
            drop_frame();
        if (!framing)
        begin
            if (b != START_BYTE)
                return;
            framing    = 1'b1;
            fill_count = 0;
            csum       = 8'h00;
        end
        // overlong frame loses this byte and the frame
        if (fill_count >= FRAME_MAX)
        begin
            drop_frame();
            return;
        end
        frame_mem[fill_count] = b;
        if (b != END_BYTE)
        begin
            if (fill_count >= 1)
                csum = csum + b;
            fill_count++;
            return;
        end
        n      = fill_count + 1;
        sum_in = csum;
        drop_frame();
        if (n < FRAME_OVERHEAD)
            return;
        plen = {frame_mem[POS_LEN_HI], frame_mem[POS_LEN_LO]};
        if (n != int'(plen) + FRAME_OVERHEAD)
            return;
        chk = sum_in - frame_mem[n - 2];
        if (chk != frame_mem[n - 2])
            return;
        cmd  = frame_mem[POS_CMD];
        elen = int'(plen) - TAG_OVERHEAD;
        if (cmd == CMD_INVENTORY && plen >= 16'd6 && elen <= EPC_MAX)
        begin
            for (int i = 0; i < elen; i++)
                queue_report(KIND_TAG, cmd, frame_mem[POS_RSSI],
                             {frame_mem[POS_PC_HI], frame_mem[POS_PC_LO]},
                             {frame_mem[POS_EPC + elen], frame_mem[POS_EPC + elen + 1]},
                             elen[3:0], i[3:0], frame_mem[POS_EPC + i], i == elen - 1);
        end
        else if (cmd == CMD_ERROR)
            queue_report(KIND_ERROR, cmd, 8'h00, 16'h0, 16'h0, 4'h0, 4'h0, 8'h00, 1'b1);
        else if (cmd == CMD_INVENTORY)
            queue_report(KIND_REJECT, cmd, 8'h00, 16'h0, 16'h0, 4'h0, 4'h0, 8'h00, 1'b1);
        else
            queue_report(KIND_OTHER, cmd, 8'h00, 16'h0, 16'h0, 4'h0, 4'h0, 8'h00, 1'b1);
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        report_t want;
        if (!rst_n)
        begin
            drop_frame();
            report_backlog.delete();
            mismatches = 0;
            backlog    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                deframe_byte(rx_byte, restart);
            if (out_valid && !out_stall)
            begin
                if (report_backlog.size() == 0)
                begin
                    $display("%0t: result with nothing pending, kind %0d command %0h",
                             $time, kind, command);
                    mismatches++;
                end
                else
                begin
                    want = report_backlog.pop_front();
                    compare_field("kind", {14'h0, want.kind}, {14'h0, kind});
                    compare_field("command", {8'h00, want.command}, {8'h00, command});
                    compare_field("rssi_dbm", {8'h00, want.rssi}, {8'h00, rssi_dbm});
                    compare_field("pc_word", want.pc, pc_word);
                    compare_field("tag_crc", want.crc, tag_crc);
                    compare_field("epc_length", {12'h0, want.elen}, {12'h0, epc_length});
                    compare_field("epc_index", {12'h0, want.eidx}, {12'h0, epc_index});
                    compare_field("epc_byte", {8'h00, want.ebyte}, {8'h00, epc_byte});
                    compare_field("last", {15'h0, want.last}, {15'h0, last});
                end
            end
            backlog = report_backlog.size();
        end
    end

endmodule : uhfrx_checker

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// regression bench for the uhf reader frame receiver
// ----------------------------------------------------------------------------
// Feeds byte requests built as whole reader frames (tag reads of every epc
// length, error frames, other commands, rejected inventory replies) mixed
// with broken frames, restarts and line noise. A checker beside the block
// rebuilds each frame and compares every result request. Both sides idle at
// random; once the result side holds off long enough to back the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import uhfrx_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD   = 400;   // result side hold-off, in cycles
    localparam int IDLE_LIMIT  = 2000;  // cycles with no accepted request
    localparam int TAIL_CYCLES = 60;    // quiet time after the last result
    localparam int ITEM_TARGET = 230;   // least byte requests in the whole run

    typedef enum logic [1:0] {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_BAD_LEN,
        FRAME_CUT
    } frame_flaw_t;

    logic        clk;
    logic        rst_n;

    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        restart;

    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [7:0]  command;
    logic signed [7:0] rssi_dbm;
    logic [15:0] pc_word;
    logic [15:0] tag_crc;
    logic [3:0]  epc_length;
    logic [3:0]  epc_index;
    logic [7:0]  epc_byte;
    logic        last;

    int          mismatches;
    int          backlog;

    // stimulus bookkeeping
    bit          tx_quiet;        // no gaps between byte requests
    int          items_sent;      // byte requests accepted so far
    int          hold_off_asked;  // bumped by stimulus, served by the receiver

    uhf_reader_frame_receiver_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .command    (command),
        .rssi_dbm   (rssi_dbm),
        .pc_word    (pc_word),
        .tag_crc    (tag_crc),
        .epc_length (epc_length),
        .epc_index  (epc_index),
        .epc_byte   (epc_byte),
        .last       (last)
    );

    uhfrx_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .command      (command),
        .rssi_dbm     (rssi_dbm),
        .pc_word      (pc_word),
        .tag_crc      (tag_crc),
        .epc_length   (epc_length),
        .epc_index    (epc_index),
        .epc_byte     (epc_byte),
        .last         (last),
        .mismatches   (mismatches),
        .backlog      (backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // any data byte except the end marker, so a frame is not cut short
    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == END_BYTE);
        return b;
    endfunction

    // one byte request; entered right after an accepting edge or at start,
    // leaves at the accepting rising edge with valid still high
    task automatic send_byte(input logic [7:0] b, input logic clr);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        restart  <= clr;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // lower valid, then hold the sender until every result has come back
    task automatic drain_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (backlog == 0);
    endtask

    // builds a frame: start, byte 1, command, length, payload, checksum, end;
    // fill below zero means random payload, else every payload byte is fill
    task automatic send_frame(input logic [7:0] cmd, input int plen,
                              input frame_flaw_t flaw, input int fill,
                              input logic lead_restart);
        logic [7:0]  fb [FRAME_MAX];
        logic [15:0] len_field;
        logic [7:0]  good;
        logic [7:0]  chk;
        int          n;
        int          cut;
        n         = plen + FRAME_OVERHEAD;
        fb[0]     = START_BYTE;
        fb[POS_CMD] = cmd;
        len_field = plen[15:0];
        // wrong length field: flip one bit, keep the end marker out of it
        if (flaw == FRAME_BAD_LEN)
        begin
            do
                len_field = plen[15:0] ^ (16'h0001 << $urandom_range(0, 15));
            while (len_field[15:8] == END_BYTE || len_field[7:0] == END_BYTE);
        end
        fb[POS_LEN_HI] = len_field[15:8];
        fb[POS_LEN_LO] = len_field[7:0];
        for (int i = POS_RSSI; i < n - 2; i++)
            fb[i] = (fill < 0) ? data_byte() : fill[7:0];
        // pick byte 1 so that the checksum itself is not the end marker
        do
        begin
            fb[1] = data_byte();
            good  = 8'h00;
            for (int i = 1; i < n - 2; i++)
                good = good + fb[i];
        end
        while (good == END_BYTE);
        chk = good;
        if (flaw == FRAME_BAD_SUM)
        begin
            do
                chk = good + 8'($urandom_range(1, 255));
            while (chk == END_BYTE);
        end
        fb[n - 2] = chk;
        fb[n - 1] = END_BYTE;
        // a cut frame is abandoned by a restart on the byte where it breaks
        cut = (flaw == FRAME_CUT) ? $urandom_range(1, n - 1) : n;
        for (int i = 0; i < cut; i++)
            send_byte(fb[i], (i == 0) ? lead_restart : 1'b0);
        if (flaw == FRAME_CUT)
            send_byte(fb[cut], 1'b1);
    endtask

    // result side: random hold-off per result, quiet stretches, one long hold
    initial
    begin : result_sink
        int gap;
        int stretch;
        int hold_off_done;
        bit rx_quiet;
        out_stall     = 1'b0;
        stretch       = 0;
        rx_quiet      = 1'b0;
        hold_off_done = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_done != hold_off_asked)
            begin
                // block fills up behind this and stalls the byte side
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_off_done = hold_off_asked;
            end
            if (stretch == 0)
            begin
                rx_quiet = ($urandom_range(0, 3) == 0);
                stretch  = $urandom_range(8, 20);
            end
            stretch--;
            gap = rx_quiet ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // watchdog on cycles with no accepted request on either side
    initial
    begin : watchdog
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("%0t: no request accepted for %0d cycles", $time, idle);
                $display("uhf_reader_frame_receiver_top regression: fail");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          pick;
        int          sel;
        int          plen;
        logic [7:0]  cmd;
        in_valid       = 1'b0;
        rx_byte        = 8'h00;
        restart        = 1'b0;
        tx_quiet       = 1'b0;
        items_sent     = 0;
        hold_off_asked = 0;
        rst_n          = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // noise while hunting, including an end marker and a restart
        send_byte(8'h00, 1'b0);
        send_byte(END_BYTE, 1'b1);
        // result side holds off from the next result on while bytes keep coming
        hold_off_asked++;
        // restart landing on a start byte mid-frame begins a new frame,
        // here the shortest tag read with rssi at its most negative
        send_byte(START_BYTE, 1'b0);
        send_byte(8'h05, 1'b0);
        send_frame(CMD_INVENTORY, 6, FRAME_GOOD, 8'h80, 1'b1);
        // longest tag read, all ones
        send_frame(CMD_INVENTORY, 5 + EPC_MAX, FRAME_GOOD, 8'hFF, 1'b0);
        // inventory reply rejected for epc length zero
        send_frame(CMD_INVENTORY, 5, FRAME_GOOD, -1, 1'b0);
        // error frame
        send_frame(CMD_ERROR, 0, FRAME_GOOD, -1, 1'b0);
        // start byte as command and as payload data
        send_frame(START_BYTE, 1, FRAME_GOOD, START_BYTE, 1'b0);
        // broken frames give nothing
        send_frame(CMD_INVENTORY, 0, FRAME_BAD_SUM, -1, 1'b0);
        send_frame(CMD_ERROR, 1, FRAME_BAD_LEN, -1, 1'b0);
        send_frame(CMD_INVENTORY, 2, FRAME_CUT, -1, 1'b0);
        // start then end right away
        send_byte(START_BYTE, 1'b0);
        send_byte(END_BYTE, 1'b0);
        // overlong: the end marker arrives with the store already full
        send_byte(START_BYTE, 1'b0);
        repeat (FRAME_MAX - 1) send_byte(data_byte(), 1'b0);
        send_byte(END_BYTE, 1'b0);
        drain_idle();

        // ---- random part: mostly well-formed frames with random content ----
        while (items_sent < ITEM_TARGET)
        begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            pick     = $urandom_range(0, 19);
            if (pick < 12)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 10)
                begin
                    cmd  = CMD_INVENTORY;
                    plen = $urandom_range(6, 5 + EPC_MAX);
                end
                else if (sel < 13)
                begin
                    cmd  = CMD_ERROR;
                    plen = $urandom_range(0, 8);
                end
                else if (sel < 18)
                begin
                    cmd  = data_byte();
                    plen = $urandom_range(0, 12);
                end
                else
                begin
                    cmd  = CMD_INVENTORY;
                    plen = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 5)
                                                       : $urandom_range(18, 40);
                end
                send_frame(cmd, plen, FRAME_GOOD, -1, $urandom_range(0, 3) == 0);
            end
            else if (pick < 16)
                send_frame(data_byte(), $urandom_range(0, 17),
                           frame_flaw_t'($urandom_range(1, 3)), -1,
                           1'($urandom_range(0, 1)));
            else if (pick < 19)
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom), 1'($urandom_range(0, 1)));
            else
            begin
                send_byte(START_BYTE, 1'b0);
                send_byte(END_BYTE, 1'b0);
            end
            // sender pauses for a full drain from time to time
            if ($urandom_range(0, 9) == 0)
                drain_idle();
        end

        drain_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && backlog == 0)
            $display("uhf_reader_frame_receiver_top regression: pass");
        else
            $display("uhf_reader_frame_receiver_top regression: fail");
        $finish;
    end

endmodule : tb_top

`default_nettype wire
